// ===== src/dwg_pkg.sv =====
// Shared types and codes of the damped wave grid engine.
`timescale 1ns / 1ps
package dwg_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_IMPULSE = 2'd1,
    KIND_STEP    = 2'd2,
    KIND_READ    = 2'd3
  } kind_t;

  localparam logic [1:0] CFG_NEIGHBOUR_GAIN = 2'd0;
  localparam logic [1:0] CFG_CENTRE_GAIN    = 2'd1;

  localparam logic [15:0] NEIGHBOUR_GAIN_RESET = 16'd16384;
  localparam logic [15:0] DAMPING_RESET        = 16'hFFFF;

  typedef struct packed {
    kind_t              kind;
    logic [5:0]         row;
    logic [5:0]         column;
    logic signed [15:0] impulse;
    logic [15:0]        damping_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] height_out;
    logic               saturated;
  } out_item_t;

  // Classified item as it waits between front and back.
  typedef struct packed {
    kind_t              kind;
    logic [5:0]         row;
    logic [5:0]         column;
    logic               in_grid;
    logic signed [15:0] impulse;
    logic [15:0]        damping_value;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [17:0] data;
  } cfg_wr_t;

endpackage

// ===== src/dwg_front.sv =====
// Front end: accepts input beats, checks the grid bounds and clamps impulse positions.
`timescale 1ns / 1ps
module dwg_front #(
  parameter int GRID_SIDE = 64
) (
  input  logic          in_valid,
  input  dwg_pkg::in_item_t in_item,
  output logic          in_stall,
  input  logic          q_full,
  input  logic          clearing,
  output logic          push,
  output dwg_pkg::cmd_t cmd
);
  import dwg_pkg::*;

  localparam int HI = GRID_SIDE - 2;

  int r_cl;
  int c_cl;

  always_comb begin
    r_cl = 32'(in_item.row);
    c_cl = 32'(in_item.column);
    if (r_cl < 1) r_cl = 1;
    if (r_cl > HI) r_cl = HI;
    if (c_cl < 1) c_cl = 1;
    if (c_cl > HI) c_cl = HI;
  end

  always_comb begin
    in_stall          = q_full || clearing;
    push              = in_valid && !in_stall;
    cmd.kind          = in_item.kind;
    cmd.impulse       = in_item.impulse;
    cmd.damping_value = in_item.damping_value;
    cmd.in_grid       = (32'(in_item.row) < GRID_SIDE) && (32'(in_item.column) < GRID_SIDE);
    if (in_item.kind == KIND_IMPULSE) begin
      cmd.row    = 6'(r_cl);
      cmd.column = 6'(c_cl);
    end else begin
      cmd.row    = in_item.row;
      cmd.column = in_item.column;
    end
  end

endmodule

// ===== src/dwg_queue.sv =====
// Two-entry queue of classified items between front and back.
`timescale 1ns / 1ps
module dwg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dwg_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output dwg_pkg::cmd_t head,
  output logic          not_empty
);
  import dwg_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== src/dwg_back.sv =====
// Back end: grid memories, clearing pass, single-cell operations and the step sweep.
`timescale 1ns / 1ps
module dwg_back #(
  parameter int GRID_SIDE   = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dwg_pkg::cfg_wr_t   cfg,
  input  logic               q_valid,
  input  dwg_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               clearing,
  output logic               out_valid,
  output dwg_pkg::out_item_t out_item,
  input  logic               out_stall
);
  import dwg_pkg::*;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIDE);
  localparam int TW    = $clog2(CELLS + GRID_SIDE + 16) + 1;
  localparam int HB    = HEIGHT_BITS;
  localparam int SW    = HB + 2;
  localparam int ACW   = HB + 20;
  localparam int QW    = HB + 5;
  localparam int PW    = HB + 22;
  localparam int XW    = HB + 24;

  localparam logic signed [XW-1:0] H_MAX = {{(XW-HB+1){1'b0}}, {(HB-1){1'b1}}};
  localparam logic signed [XW-1:0] H_MIN = {{(XW-HB+1){1'b1}}, {(HB-1){1'b0}}};
  localparam logic signed [XW-1:0] R_MAX = XW'(32767);
  localparam logic signed [XW-1:0] R_MIN = -(XW'(32768));

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_OP, S_STEP} state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [5:0] r, input logic [5:0] c);
    cell_addr = AW'(32'(r) * GRID_SIDE + 32'(c));
  endfunction

  function automatic logic clipped(input logic signed [XW-1:0] v);
    clipped = (v > H_MAX) || (v < H_MIN);
  endfunction

  function automatic logic signed [HB-1:0] clip_h(input logic signed [XW-1:0] v);
    if (v > H_MAX) clip_h = H_MAX[HB-1:0];
    else if (v < H_MIN) clip_h = H_MIN[HB-1:0];
    else clip_h = v[HB-1:0];
  endfunction

  state_t state;
  logic [AW-1:0] clr_cnt;
  cmd_t op;
  logic [AW-1:0] op_adr;
  logic [15:0] neighbour_gain;
  logic signed [17:0] centre_gain;
  logic sat_acc;

  // sweep control
  logic [TW-1:0] t;
  logic [CW-1:0] tc;
  logic s1_v;
  logic [CW-1:0] s1_col;
  logic s1_jv;
  logic [AW-1:0] jadr;
  logic [CW-1:0] jr;
  logic [CW-1:0] jc;
  logic s2_jv, s2_int, s2_last;
  logic [AW-1:0] s2_adr;

  // window
  logic signed [HB-1:0] dn_a, up_a, dn, up, rt, ct, lf;

  // arithmetic stages
  logic e1_v, e1_int, e1_last;
  logic [AW-1:0] e1_adr;
  logic signed [HB-1:0] e1_ct, e1_prev;
  logic signed [SW-1:0] e1_sum;
  logic [15:0] e1_damp;
  logic e2_v, e2_int, e2_last;
  logic [AW-1:0] e2_adr;
  logic signed [HB-1:0] e2_ct, e2_prev;
  logic signed [HB+18:0] e2_pa;
  logic signed [HB+17:0] e2_pb;
  logic [15:0] e2_damp;
  logic e3_v, e3_int, e3_last;
  logic [AW-1:0] e3_adr;
  logic signed [HB-1:0] e3_ct;
  logic signed [QW-1:0] e3_q10;
  logic [15:0] e3_damp;
  logic e4_v, e4_int, e4_last;
  logic [AW-1:0] e4_adr;
  logic signed [HB-1:0] e4_ct;
  logic signed [PW-1:0] e4_prod;

  // memories
  logic signed [HB-1:0] cur_mem  [CELLS];
  logic signed [HB-1:0] prev_mem [CELLS];
  logic [15:0]          damp_mem [CELLS];
  logic [2*HB-1:0]      lb_mem   [GRID_SIDE];
  logic signed [HB-1:0] cur_q, prev_q;
  logic [15:0]          damp_q;
  logic [2*HB-1:0]      lb_q;

  logic                 cur_we, prev_we, damp_we;
  logic [AW-1:0]        cur_waddr, cur_raddr, prev_waddr, damp_waddr;
  logic signed [HB-1:0] cur_wdata, prev_wdata;
  logic [15:0]          damp_wdata;

  logic slot_free;
  logic [AW-1:0] head_adr;
  logic signed [ACW-1:0] acc;
  logic signed [XW-1:0] d_full, imp_full, rd_full;
  logic signed [HB-1:0] d_clip, imp_clip;
  logic d_sat, imp_sat;
  logic signed [15:0] rd_h;
  logic signed [HB-1:0] t1, t2;

  assign slot_free = !out_valid || !out_stall;
  assign head_adr  = cell_addr(q_head.row, q_head.column);
  assign q_pop     = (state == S_IDLE) && q_valid && slot_free;
  assign clearing  = (state == S_CLEAR);
  assign t1        = lb_q[2*HB-1:HB];
  assign t2        = lb_q[HB-1:0];

  always_comb begin
    acc = ACW'(e2_pa) + ACW'(e2_pb) - (ACW'(e2_prev) <<< 15) + ACW'(16384);
    d_full   = (XW'(e4_prod) + XW'(32768)) >>> 16;
    d_clip   = clip_h(d_full);
    d_sat    = clipped(d_full);
    imp_full = XW'(cur_q) + XW'(op.impulse);
    imp_clip = clip_h(imp_full);
    imp_sat  = clipped(imp_full);
    rd_full  = XW'(cur_q);
    if (rd_full > R_MAX) rd_h = 16'sd32767;
    else if (rd_full < R_MIN) rd_h = -16'sd32768;
    else rd_h = rd_full[15:0];
  end

  always_comb begin
    cur_we     = 1'b0;
    cur_waddr  = clr_cnt;
    cur_wdata  = '0;
    prev_we    = 1'b0;
    prev_waddr = clr_cnt;
    prev_wdata = '0;
    damp_we    = 1'b0;
    damp_waddr = clr_cnt;
    damp_wdata = DAMPING_RESET;
    cur_raddr  = head_adr;
    case (state)
      S_CLEAR: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
        damp_we = 1'b1;
      end
      S_IDLE: begin
        if (q_pop && q_head.kind == KIND_LOAD && q_head.in_grid) begin
          damp_we    = 1'b1;
          damp_waddr = head_adr;
          damp_wdata = q_head.damping_value;
        end
      end
      S_OP: begin
        if (op.kind == KIND_IMPULSE) begin
          cur_we    = 1'b1;
          cur_waddr = op_adr;
          cur_wdata = imp_clip;
        end
      end
      S_STEP: begin
        cur_raddr  = (t < TW'(CELLS)) ? t[AW-1:0] : '0;
        cur_we     = e4_v && e4_int;
        cur_waddr  = e4_adr;
        cur_wdata  = d_clip;
        prev_we    = e4_v;
        prev_waddr = e4_adr;
        prev_wdata = e4_ct;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_waddr] <= cur_wdata;
    cur_q <= cur_mem[cur_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_q <= prev_mem[jadr];
  end

  always_ff @(posedge clk) begin
    if (damp_we) damp_mem[damp_waddr] <= damp_wdata;
    damp_q <= damp_mem[jadr];
  end

  // two row delays for the old heights streaming through the sweep
  always_ff @(posedge clk) begin
    if (s1_v) lb_mem[s1_col] <= {cur_q, t1};
    lb_q <= lb_mem[tc];
  end

  // window and arithmetic pipeline
  always_ff @(posedge clk) begin
    dn_a <= cur_q;
    up_a <= t2;
    dn   <= dn_a;
    up   <= up_a;
    rt   <= t1;
    ct   <= rt;
    lf   <= ct;
    s2_adr  <= jadr;
    s2_int  <= (jr >= CW'(1)) && (jr <= CW'(GRID_SIDE - 2)) &&
               (jc >= CW'(1)) && (jc <= CW'(GRID_SIDE - 2));
    s2_last <= (jadr == AW'(CELLS - 1));
    e1_adr  <= s2_adr;
    e1_int  <= s2_int;
    e1_last <= s2_last;
    e1_ct   <= ct;
    e1_prev <= prev_q;
    e1_damp <= damp_q;
    e1_sum  <= SW'(up) + SW'(dn) + SW'(lf) + SW'(rt);
    e2_adr  <= e1_adr;
    e2_int  <= e1_int;
    e2_last <= e1_last;
    e2_ct   <= e1_ct;
    e2_prev <= e1_prev;
    e2_damp <= e1_damp;
    e2_pa   <= $signed({1'b0, neighbour_gain}) * e1_sum;
    e2_pb   <= centre_gain * e1_ct;
    e3_adr  <= e2_adr;
    e3_int  <= e2_int;
    e3_last <= e2_last;
    e3_ct   <= e2_ct;
    e3_damp <= e2_damp;
    e3_q10  <= QW'(acc >>> 15);
    e4_adr  <= e3_adr;
    e4_int  <= e3_int;
    e4_last <= e3_last;
    e4_ct   <= e3_ct;
    e4_prod <= e3_q10 * $signed({1'b0, e3_damp});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_cnt        <= '0;
      out_valid      <= 1'b0;
      neighbour_gain <= NEIGHBOUR_GAIN_RESET;
      centre_gain    <= '0;
      sat_acc        <= 1'b0;
      t              <= '0;
      tc             <= '0;
      s1_v           <= 1'b0;
      s1_jv          <= 1'b0;
      s2_jv          <= 1'b0;
      e1_v           <= 1'b0;
      e2_v           <= 1'b0;
      e3_v           <= 1'b0;
      e4_v           <= 1'b0;
      jadr           <= '0;
      jr             <= '0;
      jc             <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_NEIGHBOUR_GAIN: neighbour_gain <= cfg.data[15:0];
          CFG_CENTRE_GAIN:    centre_gain    <= cfg.data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            op     <= q_head;
            op_adr <= head_adr;
            case (q_head.kind)
              KIND_LOAD: begin
                out_valid <= 1'b1;
                out_item  <= '0;
              end
              KIND_STEP: begin
                state   <= S_STEP;
                t       <= '0;
                tc      <= '0;
                s1_v    <= 1'b0;
                s1_jv   <= 1'b0;
                s2_jv   <= 1'b0;
                e1_v    <= 1'b0;
                e2_v    <= 1'b0;
                e3_v    <= 1'b0;
                e4_v    <= 1'b0;
                jadr    <= '0;
                jr      <= '0;
                jc      <= '0;
                sat_acc <= 1'b0;
              end
              default: state <= S_OP;
            endcase
          end
        end
        S_OP: begin
          out_valid <= 1'b1;
          if (op.kind == KIND_READ) begin
            out_item.height_out <= op.in_grid ? rd_h : '0;
            out_item.saturated  <= 1'b0;
          end else begin
            out_item.height_out <= '0;
            out_item.saturated  <= imp_sat;
          end
          state <= S_IDLE;
        end
        S_STEP: begin
          t      <= t + TW'(1);
          tc     <= (tc == CW'(GRID_SIDE - 1)) ? '0 : tc + CW'(1);
          s1_v   <= 1'b1;
          s1_col <= tc;
          s1_jv  <= (t >= TW'(GRID_SIDE + 1)) && (t < TW'(CELLS + GRID_SIDE + 1));
          if (s1_jv) begin
            jadr <= jadr + AW'(1);
            if (jc == CW'(GRID_SIDE - 1)) begin
              jc <= '0;
              jr <= jr + CW'(1);
            end else begin
              jc <= jc + CW'(1);
            end
          end
          s2_jv <= s1_jv;
          e1_v  <= s2_jv;
          e2_v  <= e1_v;
          e3_v  <= e2_v;
          e4_v  <= e3_v;
          if (e4_v && e4_int && d_sat) sat_acc <= 1'b1;
          if (e4_v && e4_last) begin
            out_valid           <= 1'b1;
            out_item.height_out <= '0;
            out_item.saturated  <= sat_acc || (e4_int && d_sat);
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/damped_wave_grid_engine.sv =====
// After the queue: a load is answered straight from the idle state, a read or impulse passes
// through the operation state, and a step sweeps one cell a cycle through the current-height port.
// Throughput: one item at a time in the back end; the front queues two more beats.
// Reset (synchronous, rst high) starts a clearing pass over every cell of the three grid
// memories; input beats stall until it ends, configuration writes are taken.
// Configuration writes complete in the cycle they are offered.
`timescale 1ns / 1ps
module damped_wave_grid_engine #(
  parameter int GRID_SIDE   = 64,
  parameter int HEIGHT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dwg_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output dwg_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);
  import dwg_pkg::*;

  cmd_t    f_cmd, q_head;
  logic    f_push, q_full, q_valid, q_pop, clearing;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  dwg_front #(.GRID_SIDE(GRID_SIDE)) u_front (
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (f_push),
    .cmd      (f_cmd)
  );

  dwg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  dwg_back #(.GRID_SIDE(GRID_SIDE), .HEIGHT_BITS(HEIGHT_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

// ===== src/dwg_checker.sv =====
// Port-level checks of the damped wave grid engine, bound to the top level.
`timescale 1ns / 1ps
module dwg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dwg_pkg::out_item_t out_item,
  input logic               cfg_ready
);
  import dwg_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed or dropped");

  // only reads carry a height, only impulses and steps carry a clip flag
  a_out_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.height_out == 16'sd0) || !out_item.saturated)
    else $error("result carries both height and clip flag");

  // leaving reset: no result pending and inputs held off for the clearing pass
  a_reset_exit: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && in_stall)
    else $error("block not quiet after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> cfg_ready)
    else $error("configuration port not ready after reset");

endmodule

bind damped_wave_grid_engine dwg_checker u_dwg_checker (.*);
